>>> rtl/brc_pkg.sv
// Shared types and constants for the byte rotate cipher engine.
package brc_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int KEY_W       = 48;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_SELECT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROTATIONS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW_HALF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH_HALF   = 3'd4;

    localparam logic [1:0] MODE_INVERT  = 2'd0;
    localparam logic [1:0] MODE_CODEBK  = 2'd1;
    localparam logic [1:0] MODE_CHAINED = 2'd2;

    typedef enum logic
    {
        ST_STREAM,
        ST_PAD
    } brc_state_t;

    // controller -> datapath
    typedef struct packed
    {
        logic step;        // produce one result into the output register
        logic pad;         // result comes from a zero pad byte
        logic final_flag;  // result is the last of the stream
        logic stream_end;  // clear position and stream start flag
    } brc_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic pos_wrap;    // current position is the last one of a block
        logic rotate_mode; // mode 1 or 2
    } brc_status_t;

endpackage

>>> rtl/brc_ctrl.sv
// Control state machine: handshakes, padding sequence and output valid.
module brc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  brc_pkg::brc_status_t status,
    output brc_pkg::brc_cmd_t    cmd
);
    import brc_pkg::*;

    brc_state_t state_reg;
    brc_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_STREAM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_STREAM:
            begin
                s_tready        = out_free;
                cmd.step        = s_tvalid && out_free;
                cmd.pad         = 1'b0;
                // a short last block keeps its position and chain for the pad bytes
                cmd.stream_end  = s_tlast && (!status.rotate_mode || status.pos_wrap);
                cmd.final_flag  = status.rotate_mode ? (s_tlast && status.pos_wrap) : s_tlast;
                if (cmd.step && s_tlast && status.rotate_mode && !status.pos_wrap)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                cmd.step       = out_free;
                cmd.pad        = 1'b1;
                cmd.final_flag = status.pos_wrap;
                cmd.stream_end = status.pos_wrap;
                if (out_free && status.pos_wrap)
                begin
                    state_next = ST_STREAM;
                end
            end
            default:
            begin
                state_next = ST_STREAM;
            end
        endcase
        out_valid_next = cmd.step ? 1'b1 : (out_valid_reg && !m_tready);
    end

endmodule

>>> rtl/brc_datapath.sv
// Datapath: config registers, chain bytes, rotate/XOR unit, output register.
module brc_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]                      in_byte,
    input  brc_pkg::brc_cmd_t               cmd,
    output brc_pkg::brc_status_t            status,
    output logic [7:0]                      out_byte,
    output logic                            out_last
);
    import brc_pkg::*;

    logic [1:0]            mode_reg;
    logic                  decrypt_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [63:0]           iv_lo_reg;
    logic [63:0]           iv_hi_reg;
    logic [7:0]            chain_reg [BLOCK_BYTES];
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic                  started_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_last_reg;

    logic [127:0]          iv_all;
    logic [7:0]            iv_byte;
    logic [7:0]            chain_cur;
    logic [2:0]            rot_amt;
    logic [7:0]            src_byte;
    logic [7:0]            pre_byte;
    logic [15:0]           rotl_wide;
    logic [15:0]           rotr_wide;
    logic [7:0]            rot_byte;
    logic [7:0]            result;
    logic [7:0]            chain_new;
    logic                  rotate_mode;
    logic                  chained;

    assign iv_all      = {iv_hi_reg, iv_lo_reg};
    assign iv_byte     = iv_all[{pos_reg, 3'b000} +: 8];
    assign chain_cur   = started_reg ? chain_reg[pos_reg] : iv_byte;
    assign rot_amt     = key_reg[pos_reg * 3 +: 3];
    assign rotate_mode = (mode_reg == MODE_CODEBK) || (mode_reg == MODE_CHAINED);
    assign chained     = (mode_reg == MODE_CHAINED);
    assign src_byte    = cmd.pad ? 8'h00 : in_byte;

    assign status.pos_wrap    = (pos_reg == POS_W'(BLOCK_BYTES - 1));
    assign status.rotate_mode = rotate_mode;

    always_comb
    begin
        // in chained mode, encrypt XORs before rotating, decrypt after
        pre_byte  = (chained && !decrypt_reg) ? (src_byte ^ chain_cur) : src_byte;
        rotl_wide = {pre_byte, pre_byte} << rot_amt;
        rotr_wide = {pre_byte, pre_byte} >> rot_amt;
        rot_byte  = decrypt_reg ? rotr_wide[7:0] : rotl_wide[15:8];
        if (!rotate_mode)
        begin
            result = src_byte ^ 8'hFF;
        end
        else if (chained && decrypt_reg)
        begin
            result = rot_byte ^ chain_cur;
        end
        else
        begin
            result = rot_byte;
        end
        chain_new = decrypt_reg ? src_byte : result;
        if (cmd.stream_end || status.pos_wrap)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_INVERT;
            decrypt_reg <= 1'b0;
            key_reg     <= '0;
            iv_lo_reg   <= '0;
            iv_hi_reg   <= '0;
            pos_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_CIPHER_MODE:    mode_reg    <= cfg_data[1:0];
                    REG_DECRYPT_SELECT: decrypt_reg <= cfg_data[0];
                    REG_KEY_ROTATIONS:  key_reg     <= cfg_data[KEY_W-1:0];
                    REG_IV_LOW_HALF:    iv_lo_reg   <= cfg_data;
                    REG_IV_HIGH_HALF:   iv_hi_reg   <= cfg_data;
                    default:            ;
                endcase
            end
            if (cmd.step)
            begin
                pos_reg     <= pos_next;
                started_reg <= !cmd.stream_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_byte_reg <= result;
            out_last_reg <= cmd.final_flag;
            for (int i = 0; i < BLOCK_BYTES; i++)
            begin
                if (chained && (POS_W'(i) == pos_reg))
                begin
                    chain_reg[i] <= chain_new;
                end
                else if (!started_reg)
                begin
                    chain_reg[i] <= iv_all[i*8 +: 8];
                end
            end
        end
    end

    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

endmodule

>>> rtl/byte_rotate_cipher_cbc_engine.sv
// Top level: one result byte per cycle unless m_tready stalls; output is registered.
// A data byte is taken each cycle the output register is free or being drained.
// After the last byte in rotate modes, zero pad bytes follow one per cycle (unless
// m_tready stalls) up to the block boundary; no input is taken meanwhile.
// Reset (rst_n low, asynchronous) clears the control, position and config registers
// and idles the stream; chain bytes reload from the IV at the next stream start.
module byte_rotate_cipher_cbc_engine
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // end_of_stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] result_byte
    output logic                            m_tlast    // final_result
);
    import brc_pkg::*;

    brc_cmd_t    cmd;
    brc_status_t status;

    assign cfg_ready = 1'b1;

    brc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    brc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
